// ----- sv/spe_pkg.sv -----
// Shared types and constants for the shortest path engine.
package spe_pkg;

  localparam int DIST_W = 24;
  localparam int COST_W = 16;
  localparam int PORT_NODE_W = 10;
  localparam logic [DIST_W-1:0] DIST_INF = 24'd10000002;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_RUN   = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DEC,
    ST_CLR,
    ST_ADD_WR,
    ST_INIT,
    ST_SCAN,
    ST_SCAN_END,
    ST_HEAD,
    ST_EDGE,
    ST_NODE,
    ST_RD,
    ST_OUT
  } state_t;

endpackage

// ----- sv/shortest_path_engine_unit.sv -----
// Dijkstra shortest path engine over a stored edge list, sequenced around three memories.
// One request at a time. After reset, and after a clear request, the head table is swept
// over all MAX_NODES entries before the next request is taken. An add reads the list head
// of its source node, then writes the edge and the new head. A run first sweeps the node
// table, then each settle step scans nodes 0..target through the node memory's single read
// port, reads the settled node's list head and walks its edge list, reading the node entry
// of each edge whose target lies in 0..target; the run ends with a read of the target.
// Results wait in an output register, so a new request can be taken while the previous
// result is still pending.
module shortest_path_engine_unit #(
  parameter int MAX_NODES = 1024,
  parameter int MAX_EDGES = 8192
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [9:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  command,
  input  logic [9:0]  from_node,
  input  logic [9:0]  to_node,
  input  logic [15:0] edge_weight,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [23:0] distance,
  output logic        reached,
  output logic        edge_overflow
);

  localparam int NW  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int EW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ECW = $clog2(MAX_EDGES + 1);
  localparam int DW  = spe_pkg::DIST_W;
  localparam int CW  = spe_pkg::COST_W;
  localparam int HDW = EW + 1;
  localparam int NDW = DW + 1;
  localparam int EDW = NW + CW + EW + 1;
  localparam logic [NW-1:0] LAST_NODE = NW'(MAX_NODES - 1);

  // memories
  logic [HDW-1:0] head_mem [MAX_NODES];
  logic [EDW-1:0] edge_mem [MAX_EDGES];
  logic [NDW-1:0] node_mem [MAX_NODES];

  logic           head_we;
  logic [NW-1:0]  head_waddr, head_raddr;
  logic [HDW-1:0] head_wdata, head_rdata;
  logic           edge_we;
  logic [EW-1:0]  edge_waddr, edge_raddr;
  logic [EDW-1:0] edge_wdata, edge_rdata;
  logic           node_we;
  logic [NW-1:0]  node_waddr, node_raddr;
  logic [NDW-1:0] node_wdata, node_rdata;

  always_ff @(posedge clk) begin
    if (head_we) head_mem[head_waddr] <= head_wdata;
    head_rdata <= head_mem[head_raddr];
  end

  always_ff @(posedge clk) begin
    if (edge_we) edge_mem[edge_waddr] <= edge_wdata;
    edge_rdata <= edge_mem[edge_raddr];
  end

  always_ff @(posedge clk) begin
    if (node_we) node_mem[node_waddr] <= node_wdata;
    node_rdata <= node_mem[node_raddr];
  end

  // registers
  spe_pkg::state_t state, state_next;
  spe_pkg::cmd_t   itm_cmd;
  logic [9:0]      itm_from, itm_to;
  logic [CW-1:0]   itm_w;
  logic [9:0]      node_count;
  logic [NW-1:0]   sweep_i, sweep_i_next;
  logic [NW-1:0]   scan_i, scan_i_next;
  logic [NW-1:0]   scan_idx;
  logic            scan_v, scan_v_next;
  logic            found, found_next;
  logic [NW-1:0]   best, best_next;
  logic [DW-1:0]   best_d, best_d_next;
  logic [NW-1:0]   e_tgt, e_tgt_next;
  logic [CW-1:0]   e_cost, e_cost_next;
  logic [EW-1:0]   e_link, e_link_next;
  logic            e_ok, e_ok_next;
  logic [ECW-1:0]  edges_used, edges_used_next;
  logic            ovf, ovf_next;
  logic [DW-1:0]   res_dist, res_dist_next;
  logic            res_has, res_has_next;
  logic            out_load;

  logic [NW-1:0]   last;
  logic            take;
  logic            cand_found;
  logic [NW-1:0]   cand_best;
  logic [DW-1:0]   cand_d;
  logic [DW-1:0]   alt;
  logic [NW-1:0]   ed_tgt;
  logic [CW-1:0]   ed_cost;
  logic [EW-1:0]   ed_link;
  logic            ed_ok;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == spe_pkg::ST_IDLE);

  assign last = (32'(node_count) >= MAX_NODES) ? LAST_NODE : NW'(node_count);

  assign take = scan_v && !node_rdata[0] && (!found || node_rdata[NDW-1:1] < best_d);
  assign cand_found = found || take;
  assign cand_best  = take ? scan_idx : best;
  assign cand_d     = take ? node_rdata[NDW-1:1] : best_d;

  assign ed_ok   = edge_rdata[0];
  assign ed_link = edge_rdata[EW:1];
  assign ed_cost = edge_rdata[EW+CW:EW+1];
  assign ed_tgt  = edge_rdata[EDW-1:EW+CW+1];
  assign alt     = best_d + DW'(e_cost);

  always_comb begin
    state_next      = state;
    sweep_i_next    = sweep_i;
    scan_i_next     = scan_i;
    scan_v_next     = 1'b0;
    found_next      = found;
    best_next       = best;
    best_d_next     = best_d;
    e_tgt_next      = e_tgt;
    e_cost_next     = e_cost;
    e_link_next     = e_link;
    e_ok_next       = e_ok;
    edges_used_next = edges_used;
    ovf_next        = ovf;
    res_dist_next   = res_dist;
    res_has_next    = res_has;
    out_load        = 1'b0;
    head_we    = 1'b0;
    head_waddr = '0;
    head_wdata = '0;
    head_raddr = '0;
    edge_we    = 1'b0;
    edge_waddr = '0;
    edge_wdata = '0;
    edge_raddr = '0;
    node_we    = 1'b0;
    node_waddr = '0;
    node_wdata = '0;
    node_raddr = '0;

    case (state)
      spe_pkg::ST_IDLE: begin
        if (in_valid) state_next = spe_pkg::ST_DEC;
      end
      spe_pkg::ST_DEC: begin
        case (itm_cmd)
          spe_pkg::CMD_CLEAR: begin
            edges_used_next = '0;
            ovf_next        = 1'b0;
            sweep_i_next    = '0;
            state_next      = spe_pkg::ST_CLR;
          end
          spe_pkg::CMD_ADD: begin
            res_dist_next = '0;
            res_has_next  = 1'b0;
            if (32'(itm_from) >= MAX_NODES || 32'(itm_to) >= MAX_NODES) begin
              state_next = spe_pkg::ST_OUT;
            end else if (32'(edges_used) >= MAX_EDGES) begin
              ovf_next   = 1'b1;
              state_next = spe_pkg::ST_OUT;
            end else begin
              head_raddr = NW'(itm_from);
              state_next = spe_pkg::ST_ADD_WR;
            end
          end
          spe_pkg::CMD_RUN: begin
            res_has_next = 1'b1;
            sweep_i_next = '0;
            state_next   = spe_pkg::ST_INIT;
          end
          default: begin
            res_has_next = 1'b1;
            if (32'(itm_from) >= MAX_NODES) begin
              res_dist_next = spe_pkg::DIST_INF;
              state_next    = spe_pkg::ST_OUT;
            end else begin
              node_raddr = NW'(itm_from);
              state_next = spe_pkg::ST_RD;
            end
          end
        endcase
      end
      spe_pkg::ST_CLR: begin
        head_we      = 1'b1;
        head_waddr   = sweep_i;
        head_wdata   = '0;
        sweep_i_next = sweep_i + 1'b1;
        if (sweep_i == LAST_NODE) state_next = spe_pkg::ST_IDLE;
      end
      spe_pkg::ST_ADD_WR: begin
        edge_we    = 1'b1;
        edge_waddr = edges_used[EW-1:0];
        edge_wdata = {NW'(itm_to), itm_w, head_rdata[EW-1:0], head_rdata[EW]};
        head_we    = 1'b1;
        head_waddr = NW'(itm_from);
        head_wdata = {1'b1, edges_used[EW-1:0]};
        edges_used_next = edges_used + 1'b1;
        state_next = spe_pkg::ST_OUT;
      end
      spe_pkg::ST_INIT: begin
        node_we      = 1'b1;
        node_waddr   = sweep_i;
        node_wdata   = {(sweep_i == '0) ? DW'(0) : spe_pkg::DIST_INF, 1'b0};
        sweep_i_next = sweep_i + 1'b1;
        if (sweep_i == LAST_NODE) begin
          scan_i_next = '0;
          found_next  = 1'b0;
          state_next  = spe_pkg::ST_SCAN;
        end
      end
      spe_pkg::ST_SCAN: begin
        found_next  = cand_found;
        best_next   = cand_best;
        best_d_next = cand_d;
        node_raddr  = scan_i;
        scan_v_next = 1'b1;
        scan_i_next = scan_i + 1'b1;
        if (scan_i == last) state_next = spe_pkg::ST_SCAN_END;
      end
      spe_pkg::ST_SCAN_END: begin
        found_next  = cand_found;
        best_next   = cand_best;
        best_d_next = cand_d;
        if (!cand_found || cand_best == last) begin
          node_raddr = last;
          state_next = spe_pkg::ST_RD;
        end else begin
          node_we    = 1'b1;
          node_waddr = cand_best;
          node_wdata = {cand_d, 1'b1};
          if (cand_d >= spe_pkg::DIST_INF) begin
            node_raddr = last;
            state_next = spe_pkg::ST_RD;
          end else begin
            head_raddr = cand_best;
            state_next = spe_pkg::ST_HEAD;
          end
        end
      end
      spe_pkg::ST_HEAD: begin
        if (head_rdata[EW]) begin
          edge_raddr = head_rdata[EW-1:0];
          state_next = spe_pkg::ST_EDGE;
        end else begin
          scan_i_next = '0;
          found_next  = 1'b0;
          state_next  = spe_pkg::ST_SCAN;
        end
      end
      spe_pkg::ST_EDGE: begin
        e_tgt_next  = ed_tgt;
        e_cost_next = ed_cost;
        e_link_next = ed_link;
        e_ok_next   = ed_ok;
        if (ed_tgt <= last) begin
          node_raddr = ed_tgt;
          state_next = spe_pkg::ST_NODE;
        end else if (ed_ok) begin
          edge_raddr = ed_link;
        end else begin
          scan_i_next = '0;
          found_next  = 1'b0;
          state_next  = spe_pkg::ST_SCAN;
        end
      end
      spe_pkg::ST_NODE: begin
        if (alt < node_rdata[NDW-1:1]) begin
          node_we    = 1'b1;
          node_waddr = e_tgt;
          node_wdata = {alt, node_rdata[0]};
        end
        if (e_ok) begin
          edge_raddr = e_link;
          state_next = spe_pkg::ST_EDGE;
        end else begin
          scan_i_next = '0;
          found_next  = 1'b0;
          state_next  = spe_pkg::ST_SCAN;
        end
      end
      spe_pkg::ST_RD: begin
        res_dist_next = node_rdata[NDW-1:1];
        state_next    = spe_pkg::ST_OUT;
      end
      spe_pkg::ST_OUT: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = spe_pkg::ST_IDLE;
        end
      end
      default: state_next = spe_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= spe_pkg::ST_CLR;
      sweep_i    <= '0;
      scan_v     <= 1'b0;
      found      <= 1'b0;
      edges_used <= '0;
      ovf        <= 1'b0;
      node_count <= 10'd1;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      sweep_i    <= sweep_i_next;
      scan_v     <= scan_v_next;
      found      <= found_next;
      edges_used <= edges_used_next;
      ovf        <= ovf_next;
      if (cfg_valid) node_count <= cfg_data;
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    scan_i   <= scan_i_next;
    scan_idx <= scan_i;
    best     <= best_next;
    best_d   <= best_d_next;
    e_tgt    <= e_tgt_next;
    e_cost   <= e_cost_next;
    e_link   <= e_link_next;
    e_ok     <= e_ok_next;
    res_dist <= res_dist_next;
    res_has  <= res_has_next;
    if (in_valid && in_ready) begin
      itm_cmd  <= spe_pkg::cmd_t'(command);
      itm_from <= from_node;
      itm_to   <= to_node;
      itm_w    <= edge_weight;
    end
    if (out_load) begin
      distance      <= res_dist;
      reached       <= res_has && (res_dist < spe_pkg::DIST_INF);
      edge_overflow <= ovf;
    end
  end

  a_edges_bound: assert property (@(posedge clk) disable iff (rst)
    32'(edges_used) <= MAX_EDGES)
    else $error("edge count beyond capacity");

  a_add_count: assert property (@(posedge clk) disable iff (rst)
    state == spe_pkg::ST_ADD_WR |=> edges_used == ECW'($past(edges_used) + 1'b1))
    else $error("edge count not advanced by add");

  a_head_link: assert property (@(posedge clk) disable iff (rst)
    (head_we && state != spe_pkg::ST_CLR) |-> head_wdata[EW])
    else $error("list head written empty outside clear");

  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == spe_pkg::ST_OUT)
    else $error("result raised outside output state");

endmodule
